/* hdl/fcfs_pkg.sv */
// Shared types and constants for the first-come-first-served scheduler.
`timescale 1ns / 1ps

package fcfs_pkg;

  localparam int ARRIVAL_W = 16;
  localparam int BURST_IN_W = 16;
  localparam int OUT_TIME_W = 32;
  localparam int PID_W = 5;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [ARRIVAL_W-1:0]  arrival;
    logic [BURST_IN_W-1:0] burst;
  } item_t;

  typedef struct packed {
    logic [OUT_TIME_W-1:0] tick_time;
    logic [PID_W-1:0]      running_pid;
    logic                  completed;
    logic [PID_W-1:0]      done_pid;
    logic [OUT_TIME_W-1:0] done_start;
    logic [OUT_TIME_W-1:0] done_finish;
    logic [OUT_TIME_W-1:0] done_turnaround;
    logic                  all_done;
  } result_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rdq_stat_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_POP_RD = 7'b0000100,
    S_POP    = 7'b0001000,
    S_RUN_RD = 7'b0010000,
    S_EXEC   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

endpackage

/* hdl/fcfs_rdq.sv */
// Ready queue of process slots, circular buffer with registered head read.
`timescale 1ns / 1ps

module fcfs_rdq #(
  parameter int DEPTH = 16,
  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int FW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [SW-1:0]      push_slot,
  input  logic               pop,
  output logic [SW-1:0]      head_slot,
  output fcfs_pkg::rdq_stat_t stat
);

  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] head;
  logic [SW-1:0] tail;
  logic [FW-1:0] fill;

  logic do_push;
  logic do_pop;

  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == FW'(DEPTH));
  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= push_slot;
    end
    head_slot <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == SW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == SW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* hdl/fcfs_process_scheduler.sv */
// Top level of the non-preemptive first-come-first-served process scheduler.
`timescale 1ns / 1ps

// A load item (func 0) is taken in the idle state and, while there is room and
// no tick has come, writes the process tables; it gives no result. A tick item
// (func 1) runs the scan and, when a process is dispatched or running, the pop
// and execute states: the arrival table sits in one memory with a single read port, and
// the sequencer walks it one entry a cycle to queue this tick's arrivals in
// index order, then pops the ready queue and updates the running process's
// remaining count. Each tick leaves exactly one result in the output
// register; while it waits there, the next tick is taken but stalls at emit.

module fcfs_process_scheduler #(
  parameter int MAX_PROCS   = 16,
  parameter int TIME_WIDTH  = 32,
  parameter int BURST_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  fcfs_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output fcfs_pkg::result_t   result
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int OW = fcfs_pkg::OUT_TIME_W;
  localparam int AW = fcfs_pkg::ARRIVAL_W;

  fcfs_pkg::state_t state;

  // process tables
  logic [AW-1:0]          arrival_mem [MAX_PROCS];
  logic [BURST_WIDTH-1:0] remaining_mem [MAX_PROCS];
  logic [TIME_WIDTH-1:0]  start_mem [MAX_PROCS];
  logic [MAX_PROCS-1:0]   finished;

  logic [TIME_WIDTH-1:0]  current_time;
  logic [TIME_WIDTH-1:0]  time_inc;
  logic [CW-1:0]          process_count;
  logic [CW-1:0]          finished_count;
  logic                   ticking_started;
  logic                   busy;
  logic [IW-1:0]          running_slot;

  logic [CW-1:0]          scan_idx;
  logic                   cmp_valid;
  logic [IW-1:0]          cmp_idx;

  logic [AW-1:0]          arr_q;
  logic [BURST_WIDTH-1:0] rem_q;
  logic [TIME_WIDTH-1:0]  start_q;
  logic [IW-1:0]          arr_addr;

  fcfs_pkg::result_t      res;
  fcfs_pkg::result_t      res_out;

  logic                   rdq_push;
  logic                   rdq_pop;
  logic [IW-1:0]          rdq_head;
  fcfs_pkg::rdq_stat_t    rdq_stat;

  logic                   accept;
  logic                   is_load;
  logic                   load_ok;
  logic [31:0]            burst32;
  logic [BURST_WIDTH-1:0] burst_m;
  logic [BURST_WIDTH-1:0] burst_eff;
  logic                   arrives_now;

  logic [BURST_WIDTH-1:0] rem_dec;
  logic                   rem_done;
  logic [TIME_WIDTH-1:0]  turnaround;
  logic [63:0]            now64;
  logic [63:0]            fin64;
  logic [63:0]            start64;
  logic [63:0]            turn64;
  logic [8:0]             pid_full;

  assign item_ready = (state == fcfs_pkg::S_IDLE);
  assign accept     = item_valid && item_ready;
  assign is_load    = (item.func == fcfs_pkg::FUNC_LOAD);
  assign load_ok    = !ticking_started && (process_count < CW'(MAX_PROCS));

  // burst is cut to BURST_WIDTH bits, and zero then counts as one
  assign burst32   = 32'(item.burst);
  assign burst_m   = burst32[BURST_WIDTH-1:0];
  assign burst_eff = (burst_m == '0) ? BURST_WIDTH'(1) : burst_m;

  assign arrives_now = (TIME_WIDTH'(arr_q) == current_time) && !finished[cmp_idx] &&
                       !(busy && (running_slot == cmp_idx));

  assign rdq_push = (state == fcfs_pkg::S_SCAN) && cmp_valid && arrives_now;
  assign rdq_pop  = (state == fcfs_pkg::S_POP);

  assign arr_addr = (state == fcfs_pkg::S_SCAN) ? scan_idx[IW-1:0] : running_slot;

  assign rem_dec    = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
  assign rem_done   = (rem_dec == '0);
  assign turnaround = time_inc - TIME_WIDTH'(arr_q);
  assign now64      = 64'(current_time);
  assign fin64      = 64'(time_inc);
  assign start64    = 64'(start_q);
  assign turn64     = 64'(turnaround);
  assign pid_full   = 9'(running_slot) + 9'd1;

  always_comb begin
    res_out          = res;
    res_out.all_done = (finished_count == process_count);
  end

  fcfs_rdq #(
    .DEPTH(MAX_PROCS)
  ) u_rdq (
    .clk      (clk),
    .rst      (rst),
    .push     (rdq_push),
    .push_slot(cmp_idx),
    .pop      (rdq_pop),
    .head_slot(rdq_head),
    .stat     (rdq_stat)
  );

  // table memories
  always_ff @(posedge clk) begin
    if (accept && is_load && load_ok) begin
      arrival_mem[process_count[IW-1:0]] <= item.arrival;
    end
    arr_q <= arrival_mem[arr_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && is_load && load_ok) begin
      remaining_mem[process_count[IW-1:0]] <= burst_eff;
    end else if (state == fcfs_pkg::S_EXEC) begin
      remaining_mem[running_slot] <= rem_dec;
    end
    rem_q <= remaining_mem[running_slot];
  end

  always_ff @(posedge clk) begin
    if (state == fcfs_pkg::S_POP) begin
      start_mem[rdq_head] <= current_time;
    end
    start_q <= start_mem[running_slot];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= fcfs_pkg::S_IDLE;
      current_time    <= '0;
      process_count   <= '0;
      finished_count  <= '0;
      ticking_started <= 1'b0;
      busy            <= 1'b0;
      running_slot    <= '0;
      finished        <= '0;
      scan_idx        <= '0;
      cmp_valid       <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != fcfs_pkg::S_EMIT)) begin
        result_valid <= 1'b0;
      end

      case (state)
        fcfs_pkg::S_IDLE: begin
          if (accept) begin
            if (is_load) begin
              if (load_ok) begin
                finished[process_count[IW-1:0]] <= 1'b0;
                process_count <= process_count + 1'b1;
              end
            end else begin
              ticking_started     <= 1'b1;
              time_inc            <= current_time + 1'b1;
              scan_idx            <= '0;
              cmp_valid           <= 1'b0;
              res.tick_time       <= now64[OW-1:0];
              res.running_pid     <= '0;
              res.completed       <= 1'b0;
              res.done_pid        <= '0;
              res.done_start      <= '0;
              res.done_finish     <= '0;
              res.done_turnaround <= '0;
              res.all_done        <= 1'b0;
              state               <= fcfs_pkg::S_SCAN;
            end
          end
        end

        fcfs_pkg::S_SCAN: begin
          // address issued this cycle is compared in the next one
          if (scan_idx != process_count) begin
            cmp_idx   <= scan_idx[IW-1:0];
            cmp_valid <= 1'b1;
            scan_idx  <= scan_idx + 1'b1;
          end else begin
            cmp_valid <= 1'b0;
            if (!busy && (!rdq_stat.empty || rdq_push)) begin
              state <= fcfs_pkg::S_POP_RD;
            end else if (busy) begin
              state <= fcfs_pkg::S_RUN_RD;
            end else begin
              state <= fcfs_pkg::S_EMIT;
            end
          end
        end

        fcfs_pkg::S_POP_RD: begin
          state <= fcfs_pkg::S_POP;
        end

        fcfs_pkg::S_POP: begin
          running_slot <= rdq_head;
          busy         <= 1'b1;
          state        <= fcfs_pkg::S_RUN_RD;
        end

        fcfs_pkg::S_RUN_RD: begin
          state <= fcfs_pkg::S_EXEC;
        end

        fcfs_pkg::S_EXEC: begin
          res.running_pid <= pid_full[fcfs_pkg::PID_W-1:0];
          if (rem_done) begin
            finished[running_slot] <= 1'b1;
            finished_count         <= finished_count + 1'b1;
            busy                   <= 1'b0;
            res.completed          <= 1'b1;
            res.done_pid           <= pid_full[fcfs_pkg::PID_W-1:0];
            res.done_start         <= start64[OW-1:0];
            res.done_finish        <= fin64[OW-1:0];
            res.done_turnaround    <= turn64[OW-1:0];
          end
          state <= fcfs_pkg::S_EMIT;
        end

        fcfs_pkg::S_EMIT: begin
          if (!result_valid || result_ready) begin
            result       <= res_out;
            result_valid <= 1'b1;
            current_time <= time_inc;
            state        <= fcfs_pkg::S_IDLE;
          end
        end

        default: begin
          state <= fcfs_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sim/fcfs_sched_checker.sv */
// Checker for the FCFS scheduler: predicts each tick report and compares it with the block's output.
`timescale 1ns / 1ps

module fcfs_sched_checker #(
  parameter int PROC_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  fcfs_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  fcfs_pkg::result_t result,
  output int                fail_count,
  output int                outstanding
);

  localparam int REPORT_LIMIT = 10;

  // predicted scheduler state
  logic [15:0] arr_tab   [PROC_SLOTS];
  logic [15:0] left_tab  [PROC_SLOTS];
  logic [31:0] start_tab [PROC_SLOTS];
  bit          done_mark [PROC_SLOTS];
  int          ready_q   [PROC_SLOTS];
  int          rq_head, rq_tail, rq_fill;
  bit          cpu_busy;
  int          run_slot;
  logic [31:0] now_t;
  int          n_procs, n_done;
  bit          ticking;

  fcfs_pkg::result_t tick_reports_due[$];
  int errors, reported;

  function automatic void admit_process(fcfs_pkg::item_t req);
    logic [15:0] b;
    if (ticking || n_procs >= PROC_SLOTS) return;
    b = req.burst;
    if (b == 16'd0) b = 16'd1;
    arr_tab[n_procs]   = req.arrival;
    left_tab[n_procs]  = b;
    start_tab[n_procs] = '0;
    done_mark[n_procs] = 1'b0;
    n_procs++;
  endfunction

  function automatic fcfs_pkg::result_t next_tick_report();
    fcfs_pkg::result_t r;
    logic [31:0] fin;
    ticking = 1'b1;
    // arrivals join in index order; a running process is never requeued
    for (int i = 0; i < n_procs; i++) begin
      if ({16'd0, arr_tab[i]} == now_t && !done_mark[i] && !(cpu_busy && run_slot == i) &&
          rq_fill < PROC_SLOTS) begin
        ready_q[rq_tail] = i;
        rq_tail = (rq_tail + 1) % PROC_SLOTS;
        rq_fill++;
      end
    end
    if (!cpu_busy && rq_fill > 0) begin
      run_slot = ready_q[rq_head];
      rq_head = (rq_head + 1) % PROC_SLOTS;
      rq_fill--;
      cpu_busy = 1'b1;
      start_tab[run_slot] = now_t;
    end
    r = '0;
    r.tick_time = now_t;
    if (cpu_busy) begin
      r.running_pid = 5'(run_slot + 1);
      if (left_tab[run_slot] != 16'd0) left_tab[run_slot]--;
      if (left_tab[run_slot] == 16'd0) begin
        fin = now_t + 32'd1;
        done_mark[run_slot] = 1'b1;
        n_done++;
        cpu_busy = 1'b0;
        r.completed       = 1'b1;
        r.done_pid        = 5'(run_slot + 1);
        r.done_start      = start_tab[run_slot];
        r.done_finish     = fin;
        r.done_turnaround = fin - {16'd0, arr_tab[run_slot]};
      end
    end
    r.all_done = (n_done == n_procs);
    now_t = now_t + 32'd1;
    return r;
  endfunction

  always @(posedge clk) begin
    fcfs_pkg::result_t want;
    bit bad;
    if (rst) begin
      for (int i = 0; i < PROC_SLOTS; i++) begin
        arr_tab[i]   = '0;
        left_tab[i]  = '0;
        start_tab[i] = '0;
        done_mark[i] = 1'b0;
        ready_q[i]   = 0;
      end
      rq_head = 0;
      rq_tail = 0;
      rq_fill = 0;
      cpu_busy = 1'b0;
      run_slot = 0;
      now_t = '0;
      n_procs = 0;
      n_done = 0;
      ticking = 1'b0;
      tick_reports_due.delete();
      errors = 0;
      reported = 0;
    end else begin
      // compare before predicting: a result cannot leave in the cycle its request enters
      if (result_valid && result_ready) begin
        if (tick_reports_due.size() == 0) begin
          errors++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("unexpected result: t=%0d run=%0d", result.tick_time, result.running_pid);
          end
        end else begin
          want = tick_reports_due.pop_front();
          bad = 1'b0;
          if (result.tick_time !== want.tick_time) bad = 1'b1;
          if (result.running_pid !== want.running_pid) bad = 1'b1;
          if (result.completed !== want.completed) bad = 1'b1;
          if (result.done_pid !== want.done_pid) bad = 1'b1;
          if (result.done_start !== want.done_start) bad = 1'b1;
          if (result.done_finish !== want.done_finish) bad = 1'b1;
          if (result.done_turnaround !== want.done_turnaround) bad = 1'b1;
          if (result.all_done !== want.all_done) bad = 1'b1;
          if (bad) begin
            errors++;
            if (reported < REPORT_LIMIT) begin
              reported++;
              $display("mismatch exp: t=%0d run=%0d c=%0b pid=%0d s=%0d f=%0d ta=%0d all=%0b",
                       want.tick_time, want.running_pid, want.completed, want.done_pid,
                       want.done_start, want.done_finish, want.done_turnaround, want.all_done);
              $display("         got: t=%0d run=%0d c=%0b pid=%0d s=%0d f=%0d ta=%0d all=%0b",
                       result.tick_time, result.running_pid, result.completed, result.done_pid,
                       result.done_start, result.done_finish, result.done_turnaround,
                       result.all_done);
            end
          end
        end
      end
      if (item_valid && item_ready) begin
        if (item.func == fcfs_pkg::FUNC_TICK)
          tick_reports_due.insert(tick_reports_due.size(), next_tick_report());
        else admit_process(item);
      end
    end
    fail_count  <= errors;
    outstanding <= tick_reports_due.size();
  end

endmodule

/* sim/fcfs_process_scheduler_tb.sv */
// Testbench top for the FCFS scheduler: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module fcfs_process_scheduler_tb;

  localparam int N_TICKS     = 1770;
  localparam int PRESSURE_AT = 1600;
  localparam int DRAIN_AT    = 1680;
  localparam int LONG_HOLD   = 3000;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  fcfs_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  fcfs_pkg::result_t result;

  int fail_count;
  int outstanding;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left = 0;
  int cycle_count = 0;

  fcfs_process_scheduler dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  fcfs_sched_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left--;
      end else if (hold_asked != hold_given) begin
        hold_given++;
        hold_left = LONG_HOLD - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic fcfs_pkg::item_t request_of(logic f, logic [15:0] a, logic [15:0] b);
    fcfs_pkg::item_t r;
    r.func    = f;
    r.arrival = a;
    r.burst   = b;
    return r;
  endfunction

  task automatic offer_request(input fcfs_pkg::item_t req);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item       <= req;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    logic [15:0] arr;
    logic [15:0] bur;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // three processes at time zero in index order, bursts of zero, one and three
    offer_request(request_of(fcfs_pkg::FUNC_LOAD, 16'd0, 16'd0));
    offer_request(request_of(fcfs_pkg::FUNC_LOAD, 16'd0, 16'd1));
    offer_request(request_of(fcfs_pkg::FUNC_LOAD, 16'd0, 16'd3));
    offer_request(request_of(fcfs_pkg::FUNC_LOAD, 16'd1, 16'd2));
    // leaves the CPU idle for a stretch before it arrives
    offer_request(request_of(fcfs_pkg::FUNC_LOAD, 16'd20, 16'd1));
    arr = 16'd20;
    for (int n = 5; n < 16; n++) begin
      if ($urandom_range(2) != 0) arr = 16'($urandom_range(1000, 30));
      bur = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(120, 1));
      offer_request(request_of(fcfs_pkg::FUNC_LOAD, arr, bur));
    end
    // table full: dropped
    offer_request(request_of(fcfs_pkg::FUNC_LOAD, 16'hFFFF, 16'hFFFF));
    repeat (5) offer_request(request_of(fcfs_pkg::FUNC_TICK, 16'($urandom), 16'($urandom)));
    // loads after ticking has begun are dropped
    offer_request(request_of(fcfs_pkg::FUNC_LOAD, 16'd0, 16'd0));
    offer_request(request_of(fcfs_pkg::FUNC_LOAD, 16'h5A5A, 16'hA5A5));

    for (int n = 0; n < N_TICKS; n++) begin
      if (n < 400) begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end else if (n < 800) begin
        tx_idle_pct = 51;
        rx_stall_pct = 0;
      end else if (n < 1200) begin
        tx_idle_pct = 0;
        rx_stall_pct = 51;
      end else if (n < PRESSURE_AT) begin
        tx_idle_pct = 21;
        rx_stall_pct = 21;
      end else begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      // long result hold-off while requests keep coming, so the input backs up
      if (n == PRESSURE_AT) hold_asked++;
      if (n == DRAIN_AT) wait_drained();
      if ($urandom_range(29) == 0)
        offer_request(request_of(fcfs_pkg::FUNC_LOAD, 16'($urandom), 16'($urandom)));
      offer_request(request_of(fcfs_pkg::FUNC_TICK, 16'($urandom), 16'($urandom)));
    end

    wait_drained();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
